/* rtl/tfn_pkg.sv */
// Shared constants, types and helper functions for the triangle face normal pipeline.
// Depends on nothing; every rtl file imports it.
package tfn_pkg;

  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int OUT_BITS             = 16;
  // The largest normalized magnitude sits in [2^30, 2^31).
  localparam int MAG_BITS             = 31;
  localparam int SUMSQ_BITS           = 64;
  localparam int ROOT_BITS            = 32;
  localparam int QUO_BITS             = 32;
  localparam int SHIFT_BITS           = 7;

  // Control that travels beside the data from stage to stage.
  typedef struct packed {
    logic       valid;
    logic       degenerate;
    logic [2:0] neg;
  } tfn_ctl_t;

endpackage

/* rtl/triangle_face_normal_top.sv */
// Top level of the triangle face normal pipeline: cross product, square root, divide, output.
// Depends on tfn_pkg, tfn_cross, tfn_sqrt and tfn_div.
//
// One triangle is taken per clock whenever start is high; busy is always low because
// the pipeline never stalls, and the receiver must take each result in the cycle that
// done is high. The square root and divider are pipelined, one result bit per stage.
// Degenerate triangles give a zero normal with degenerate set.
module triangle_face_normal_top #(
  parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_BITS-1:0]         vertex_a_x, vertex_a_y, vertex_a_z,
  input  logic signed [COORD_BITS-1:0]         vertex_b_x, vertex_b_y, vertex_b_z,
  input  logic signed [COORD_BITS-1:0]         vertex_c_x, vertex_c_y, vertex_c_z,
  output logic                                 done,
  output logic signed [tfn_pkg::OUT_BITS-1:0]  normal_x, normal_y, normal_z,
  output logic                                 degenerate
);
  import tfn_pkg::*;

  tfn_ctl_t cr_ctl, sq_ctl, dv_ctl;
  logic [MAG_BITS-1:0] cu0, cu1, cu2, su0, su1, su2;
  logic [ROOT_BITS-1:0] root;
  logic [QUO_BITS-1:0] q0, q1, q2;

  assign busy = 1'b0;

  tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk, .rst, .in_valid(start && !busy),
    .ax(vertex_a_x), .ay(vertex_a_y), .az(vertex_a_z),
    .bx(vertex_b_x), .by(vertex_b_y), .bz(vertex_b_z),
    .cx(vertex_c_x), .cy(vertex_c_y), .cz(vertex_c_z),
    .ctl(cr_ctl), .u0(cu0), .u1(cu1), .u2(cu2)
  );

  tfn_sqrt u_sqrt (
    .clk, .rst, .in_ctl(cr_ctl), .in_u0(cu0), .in_u1(cu1), .in_u2(cu2),
    .ctl(sq_ctl), .u0(su0), .u1(su1), .u2(su2), .root(root)
  );

  tfn_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
    .clk, .rst, .in_ctl(sq_ctl), .in_u0(su0), .in_u1(su1), .in_u2(su2),
    .in_root(root), .ctl(dv_ctl), .q0(q0), .q1(q1), .q2(q2)
  );

  localparam logic [QUO_BITS-1:0] OMAX = QUO_BITS'((1 << (OUT_BITS - 1)) - 1);

  // Saturate, apply sign and zero out degenerate results.
  function automatic logic [OUT_BITS-1:0] fin(input logic [QUO_BITS-1:0] q,
                                              input logic neg, input logic dg);
    logic [OUT_BITS-1:0] m;
    m = (q > OMAX) ? OUT_BITS'(OMAX) : q[OUT_BITS-1:0];
    if (dg)       fin = '0;
    else if (neg) fin = -m;
    else          fin = m;
  endfunction

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_ctl.valid;
    normal_x   <= fin(q0, dv_ctl.neg[0], dv_ctl.degenerate);
    normal_y   <= fin(q1, dv_ctl.neg[1], dv_ctl.degenerate);
    normal_z   <= fin(q2, dv_ctl.neg[2], dv_ctl.degenerate);
    degenerate <= dv_ctl.degenerate;
  end

`ifndef SYNTHESIS
  // A degenerate result always carries a zero normal.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("degenerate result with nonzero normal");

  // A non-degenerate normal has at least one nonzero component.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> normal_x != 0 || normal_y != 0 || normal_z != 0)
    else $error("zero normal without degenerate flag");

  // The pipeline never asserts busy.
  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy asserted");
`endif

endmodule

/* rtl/tfn_cross.sv */
// Edge vectors, cross product and magnitude normalization (front stages).
// Depends on tfn_pkg.
module tfn_cross #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [COORD_BITS-1:0]   ax, ay, az, bx, by, bz, cx, cy, cz,
  output tfn_pkg::tfn_ctl_t              ctl,
  output logic [tfn_pkg::MAG_BITS-1:0]   u0, u1, u2
);
  import tfn_pkg::*;

  localparam int EDGE_SHIFT = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int EB  = COORD_BITS + 1 - EDGE_SHIFT;
  localparam int PB  = 2 * EB;
  localparam int CB  = PB + 1;
  localparam int UB  = CB;
  localparam int WB  = (UB > MAG_BITS) ? UB + MAG_BITS : 2 * MAG_BITS;

  logic signed [COORD_BITS:0] d1x, d1y, d1z, d2x, d2y, d2z;
  logic signed [EB-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PB-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [CB-1:0] c0, c1, c2;
  logic [UB-1:0] m0, m1, m2, mx;
  logic s1_valid, s2_valid, s3_valid;
  logic signed [CB-1:0] r0, r1, r2;
  logic [UB-1:0] a0, a1, a2, amax;
  logic [SHIFT_BITS-1:0] blen;
  logic [WB-1:0] w0, w1, w2;

  // Stage 1: edges and six partial products.
  always_comb begin
    d1x = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
    d1y = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
    d1z = {az[COORD_BITS-1], az} - {bz[COORD_BITS-1], bz};
    d2x = {bx[COORD_BITS-1], bx} - {cx[COORD_BITS-1], cx};
    d2y = {by[COORD_BITS-1], by} - {cy[COORD_BITS-1], cy};
    d2z = {bz[COORD_BITS-1], bz} - {cz[COORD_BITS-1], cz};
    e1x = EB'(d1x >>> EDGE_SHIFT);
    e1y = EB'(d1y >>> EDGE_SHIFT);
    e1z = EB'(d1z >>> EDGE_SHIFT);
    e2x = EB'(d2x >>> EDGE_SHIFT);
    e2y = EB'(d2y >>> EDGE_SHIFT);
    e2z = EB'(d2z >>> EDGE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_valid;
    p0 <= e1y * e2z;
    p1 <= e1z * e2y;
    p2 <= e1z * e2x;
    p3 <= e1x * e2z;
    p4 <= e1x * e2y;
    p5 <= e1y * e2x;
  end

  // Stage 2: cross components.
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    r0 <= CB'(p0) - CB'(p1);
    r1 <= CB'(p2) - CB'(p3);
    r2 <= CB'(p4) - CB'(p5);
  end

  // Stage 3: magnitudes, signs and the largest magnitude.
  always_comb begin
    m0 = r0[CB-1] ? UB'(-r0) : UB'(r0);
    m1 = r1[CB-1] ? UB'(-r1) : UB'(r1);
    m2 = r2[CB-1] ? UB'(-r2) : UB'(r2);
    mx = (m0 > m1) ? m0 : m1;
    if (m2 > mx) mx = m2;
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
    c0   <= r0;
    c1   <= r1;
    c2   <= r2;
    a0   <= m0;
    a1   <= m1;
    a2   <= m2;
    amax <= mx;
  end

  // Priority encode the bit length of the largest magnitude.
  always_comb begin
    blen = '0;
    for (int i = 0; i < UB; i++) begin
      if (amax[i]) blen = SHIFT_BITS'(i + 1);
    end
  end

  // Stage 4: shift all magnitudes alike so the largest lands in [2^30, 2^31).
  always_comb begin
    w0 = WB'(a0) << MAG_BITS;
    w1 = WB'(a1) << MAG_BITS;
    w2 = WB'(a2) << MAG_BITS;
    w0 = w0 >> blen;
    w1 = w1 >> blen;
    w2 = w2 >> blen;
  end

  always_ff @(posedge clk) begin
    if (rst) ctl.valid <= 1'b0;
    else     ctl.valid <= s3_valid;
    ctl.degenerate <= (amax == '0);
    ctl.neg        <= {c2[CB-1], c1[CB-1], c0[CB-1]};
    u0 <= w0[MAG_BITS-1:0];
    u1 <= w1[MAG_BITS-1:0];
    u2 <= w2[MAG_BITS-1:0];
  end

endmodule

/* rtl/tfn_sqrt.sv */
// Sum of squares and a pipelined integer square root, one result bit per stage.
// Depends on tfn_pkg.
module tfn_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  tfn_pkg::tfn_ctl_t              in_ctl,
  input  logic [tfn_pkg::MAG_BITS-1:0]   in_u0, in_u1, in_u2,
  output tfn_pkg::tfn_ctl_t              ctl,
  output logic [tfn_pkg::MAG_BITS-1:0]   u0, u1, u2,
  output logic [tfn_pkg::ROOT_BITS-1:0]  root
);
  import tfn_pkg::*;

  localparam int NS = ROOT_BITS;

  // Squares, then their sum.
  tfn_ctl_t sq_ctl, sm_ctl;
  logic [2*MAG_BITS-1:0] q0, q1, q2;
  logic [MAG_BITS-1:0] su0, su1, su2, mu0, mu1, mu2;
  logic [SUMSQ_BITS-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) sq_ctl.valid <= 1'b0;
    else     sq_ctl.valid <= in_ctl.valid;
    sq_ctl.degenerate <= in_ctl.degenerate;
    sq_ctl.neg        <= in_ctl.neg;
    q0 <= in_u0 * in_u0;
    q1 <= in_u1 * in_u1;
    q2 <= in_u2 * in_u2;
    su0 <= in_u0;
    su1 <= in_u1;
    su2 <= in_u2;
  end

  always_ff @(posedge clk) begin
    if (rst) sm_ctl.valid <= 1'b0;
    else     sm_ctl.valid <= sq_ctl.valid;
    sm_ctl.degenerate <= sq_ctl.degenerate;
    sm_ctl.neg        <= sq_ctl.neg;
    sum <= SUMSQ_BITS'(q0) + SUMSQ_BITS'(q1) + SUMSQ_BITS'(q2);
    mu0 <= su0;
    mu1 <= su1;
    mu2 <= su2;
  end

  // Restoring square root: stage k decides root bit NS-1-k.
  tfn_ctl_t              st_ctl [NS+1];
  logic [SUMSQ_BITS-1:0] st_rem [NS+1];
  logic [ROOT_BITS-1:0]  st_root [NS+1];
  logic [MAG_BITS-1:0]   st_u0 [NS+1], st_u1 [NS+1], st_u2 [NS+1];

  assign st_ctl[0]  = sm_ctl;
  assign st_rem[0]  = sum;
  assign st_root[0] = '0;
  assign st_u0[0]   = mu0;
  assign st_u1[0]   = mu1;
  assign st_u2[0]   = mu2;

  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam int B = NS - 1 - k;
    logic [SUMSQ_BITS+1:0] trial;
    always_comb begin
      trial = ((SUMSQ_BITS+2)'(st_root[k]) << (B + 1)) + ((SUMSQ_BITS+2)'(1) << (2 * B));
    end
    always_ff @(posedge clk) begin
      if (rst) st_ctl[k+1].valid <= 1'b0;
      else     st_ctl[k+1].valid <= st_ctl[k].valid;
      st_ctl[k+1].degenerate <= st_ctl[k].degenerate;
      st_ctl[k+1].neg        <= st_ctl[k].neg;
      st_u0[k+1] <= st_u0[k];
      st_u1[k+1] <= st_u1[k];
      st_u2[k+1] <= st_u2[k];
      if ((SUMSQ_BITS+2)'(st_rem[k]) >= trial) begin
        st_rem[k+1]  <= st_rem[k] - SUMSQ_BITS'(trial);
        st_root[k+1] <= st_root[k] | (ROOT_BITS'(1) << B);
      end else begin
        st_rem[k+1]  <= st_rem[k];
        st_root[k+1] <= st_root[k];
      end
    end
  end

  assign ctl  = st_ctl[NS];
  assign root = st_root[NS];
  assign u0   = st_u0[NS];
  assign u1   = st_u1[NS];
  assign u2   = st_u2[NS];

endmodule

/* rtl/tfn_div.sv */
// Pipelined restoring divider: rounded u * 2^F / L for three components at once.
// Depends on tfn_pkg.
module tfn_div #(
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tfn_pkg::tfn_ctl_t              in_ctl,
  input  logic [tfn_pkg::MAG_BITS-1:0]   in_u0, in_u1, in_u2,
  input  logic [tfn_pkg::ROOT_BITS-1:0]  in_root,
  output tfn_pkg::tfn_ctl_t              ctl,
  output logic [tfn_pkg::QUO_BITS-1:0]   q0, q1, q2
);
  import tfn_pkg::*;

  // Quotient never exceeds 2^F, so F+1 bits decide it.
  localparam int QB = NORMAL_FRAC_BITS + 1;
  localparam int NB = MAG_BITS + NORMAL_FRAC_BITS + 1;
  localparam int RB = ROOT_BITS + 1;

  typedef logic [NB-1:0] num_t;

  tfn_ctl_t            st_ctl [QB+1];
  num_t                st_n [QB+1][3];
  logic [RB-1:0]       st_r [QB+1][3];
  logic [ROOT_BITS-1:0] st_d [QB+1];

  assign st_ctl[0] = in_ctl;
  assign st_d[0]   = in_root;
  assign st_n[0][0] = (num_t'(in_u0) << NORMAL_FRAC_BITS) + num_t'(in_root >> 1);
  assign st_n[0][1] = (num_t'(in_u1) << NORMAL_FRAC_BITS) + num_t'(in_root >> 1);
  assign st_n[0][2] = (num_t'(in_u2) << NORMAL_FRAC_BITS) + num_t'(in_root >> 1);

  // Numerator is below 2^(QB) * L, so the top NB-QB bits seed the remainder.
  for (genvar j = 0; j < 3; j++) begin : g_seed
    assign st_r[0][j] = RB'(st_n[0][j] >> QB);
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) st_ctl[k+1].valid <= 1'b0;
      else     st_ctl[k+1].valid <= st_ctl[k].valid;
      st_ctl[k+1].degenerate <= st_ctl[k].degenerate;
      st_ctl[k+1].neg        <= st_ctl[k].neg;
      st_d[k+1] <= st_d[k];
    end
    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [RB-1:0] t;
      assign t = {st_r[k][j][RB-2:0], st_n[k][j][QB-1-k]};
      always_ff @(posedge clk) begin
        if (t >= RB'(st_d[k])) begin
          st_r[k+1][j] <= t - RB'(st_d[k]);
          st_n[k+1][j] <= st_n[k][j] | (num_t'(1) << (QB - 1 - k));
        end else begin
          st_r[k+1][j] <= t;
          st_n[k+1][j] <= st_n[k][j] & ~(num_t'(1) << (QB - 1 - k));
        end
      end
    end
  end

  assign ctl = st_ctl[QB];
  assign q0  = QUO_BITS'(st_n[QB][0][QB-1:0]);
  assign q1  = QUO_BITS'(st_n[QB][1][QB-1:0]);
  assign q2  = QUO_BITS'(st_n[QB][2][QB-1:0]);

endmodule

/* verif/tfn_checker.sv */
// Checker for the triangle face normal block: predicts each normal from the accepted
// triangle and compares every done strobe against the oldest prediction.
// Depends on tfn_pkg for the output width.
`timescale 1ns / 1ps
module tfn_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] vertex_a_x, vertex_a_y, vertex_a_z,
  input  logic signed [15:0] vertex_b_x, vertex_b_y, vertex_b_z,
  input  logic signed [15:0] vertex_c_x, vertex_c_y, vertex_c_z,
  input  logic               done,
  input  logic signed [tfn_pkg::OUT_BITS-1:0] normal_x, normal_y, normal_z,
  input  logic               degenerate,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count,
  output int                 degenerate_count
);

  localparam int FRAC = 14;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  normal_t expected_normals[$];

  // Integer square root by the bit-pair method.
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Exact cross product of the edges, then normalization to Q1.14.
  function automatic normal_t face_normal(
    input logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    longint e1[3], e2[3], cr[3];
    logic [63:0] mag[3], peak, sumsq, len, q;
    int bl;
    normal_t n;
    e1[0] = longint'(ax) - longint'(bx);
    e1[1] = longint'(ay) - longint'(by);
    e1[2] = longint'(az) - longint'(bz);
    e2[0] = longint'(bx) - longint'(cx);
    e2[1] = longint'(by) - longint'(cy);
    e2[2] = longint'(bz) - longint'(cz);
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? 64'(-cr[i]) : 64'(cr[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    n = '0;
    if (peak == 0) begin
      n.degen = 1'b1;
      return n;
    end
    bl = 0;
    while ((peak >> bl) != 0) bl++;
    for (int i = 0; i < 3; i++) begin
      if (bl < 31) mag[i] = mag[i] << (31 - bl);
      else if (bl > 31) mag[i] = mag[i] >> (bl - 31);
    end
    sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = root_floor(sumsq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC) + (len >> 1)) / len;
      if (q > 64'd32767) q = 64'd32767;
      if (cr[i] < 0) q = -q;
      if (i == 0) n.nx = q[15:0];
      else if (i == 1) n.ny = q[15:0];
      else n.nz = q[15:0];
    end
    return n;
  endfunction

  // Record predictions on accepted transactions and check each strobed result.
  always @(posedge clk) begin
    normal_t got;
    normal_t want;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
      degenerate_count <= 0;
      pending <= 0;
    end else begin
      if (start && !busy)
        expected_normals.push_back(face_normal(vertex_a_x, vertex_a_y, vertex_a_z,
          vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z));
      if (done) begin
        got = {normal_x, normal_y, normal_z, degenerate};
        result_count <= result_count + 1;
        if (degenerate) degenerate_count <= degenerate_count + 1;
        if (expected_normals.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_normals.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("ERROR: normal mismatch exp (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                want.nx, want.ny, want.nz, want.degen,
                got.nx, got.ny, got.nz, got.degen);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Number of accepted transactions still waiting for their result.
      pending <= expected_normals.size();
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the triangle face normal testbench: clock, reset, triangle stimulus and verdict.
// Depends on tfn_pkg, triangle_face_normal_top and tfn_checker.
`timescale 1ns / 1ps
module testbench;

  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] vertex_a_x = '0, vertex_a_y = '0, vertex_a_z = '0;
  logic signed [15:0] vertex_b_x = '0, vertex_b_y = '0, vertex_b_z = '0;
  logic signed [15:0] vertex_c_x = '0, vertex_c_y = '0, vertex_c_z = '0;
  logic done;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic degenerate;
  int fail_count, pending, result_count, degenerate_count;
  int idle_pct;
  int sent_count;
  int stall_cycles;

  always #5 clk = ~clk;

  triangle_face_normal_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y), .vertex_a_z(vertex_a_z),
    .vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y), .vertex_b_z(vertex_b_z),
    .vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y), .vertex_c_z(vertex_c_z),
    .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  tfn_checker u_checker (.*);

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("triangle_face_normal_top verification failed");
      $finish;
    end
  end

  // Drive one triangle and hold it until accepted, with random idle cycles first.
  task automatic send_triangle(input logic signed [15:0] v[9]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {vertex_a_x, vertex_a_y, vertex_a_z} <= {v[0], v[1], v[2]};
    {vertex_b_x, vertex_b_y, vertex_b_z} <= {v[3], v[4], v[5]};
    {vertex_c_x, vertex_c_y, vertex_c_z} <= {v[6], v[7], v[8]};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // Coordinates biased toward extremes, small values and full range.
  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(5))
      0: return 16'(16'sh7fff - $urandom_range(3));
      1: return 16'(16'sh8000 + $urandom_range(3));
      2: return 16'($urandom_range(15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random triangles, some collinear or with repeated vertices to reach degeneracy.
  task automatic random_triangles(input int count);
    logic signed [15:0] v[9];
    int k;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) v[i] = pick_coord();
      case ($urandom_range(9))
        0: for (int i = 0; i < 3; i++) v[3 + i] = v[i];
        1: for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
        2: begin
          // c = b + (b - a) * k keeps the three points on one line.
          k = $urandom_range(2);
          for (int i = 0; i < 3; i++) v[i] = 16'($urandom_range(255) - 128);
          for (int i = 0; i < 3; i++) v[3 + i] = 16'($urandom_range(255) - 128);
          for (int i = 0; i < 3; i++) v[6 + i] = 16'(v[3 + i] + (v[3 + i] - v[i]) * k);
        end
        default: ;
      endcase
      send_triangle(v);
    end
  endtask

  initial begin
    logic signed [15:0] v[9];
    idle_pct = 24;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: degenerate, unit axes, extremes and tiny cross products.
    v = '{default: 16'sd0};
    send_triangle(v);
    v = '{16'sd8192, 0, 0, 0, 0, 0, 0, 16'sd8192, 0};
    send_triangle(v);
    v = '{0, 16'sd8192, 0, 0, 0, 0, 0, 0, 16'sd8192};
    send_triangle(v);
    v = '{0, 0, 16'sd8192, 0, 0, 0, 16'sd8192, 0, 0};
    send_triangle(v);
    v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh7fff};
    send_triangle(v);
    v = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh8000, 16'sh7fff};
    send_triangle(v);
    v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
          16'sh8000, 16'sh8000, 16'sh8000};
    send_triangle(v);
    v = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
    send_triangle(v);
    v = '{-1, 0, 0, 0, 0, 0, 0, -1, 0};
    send_triangle(v);
    v = '{1, 1, 1, 2, 2, 2, 3, 3, 3};
    send_triangle(v);
    v = '{16'sh7fff, 0, 0, 16'sh8000, 0, 0, 16'sh8000, 16'sh7fff, 16'sh7fff};
    send_triangle(v);
    v = '{16'sh5555, 16'shaaaa, 16'sh0f0f, 16'shf0f0, 16'sh3333, 16'shcccc,
          16'sh00ff, 16'shff00, 16'sh1234};
    send_triangle(v);

    random_triangles(560);
    // Let the pipeline drain completely before changing the pacing.
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    idle_pct = 45;
    random_triangles(560);
    idle_pct = 0;
    random_triangles(570);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d triangles, checked %0d normals, %0d of them degenerate.",
      sent_count, result_count, degenerate_count);
    if (fail_count == 0 && pending == 0) begin
      $display("triangle_face_normal_top verification clean");
    end else begin
      $display("triangle_face_normal_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_sqrt.sv
rtl/tfn_div.sv
rtl/triangle_face_normal_top.sv
verif/tfn_checker.sv
verif/testbench.sv
